>>> hdl/pulse_width_symbol_decoder_core_defines.svh
// assertion macros for the pulse width symbol decoder
// needs clk and rst_n in the scope where a macro is used
`ifndef PULSE_WIDTH_SYMBOL_DECODER_CORE_DEFINES_SVH
`define PULSE_WIDTH_SYMBOL_DECODER_CORE_DEFINES_SVH

// same-cycle implication
`define PWSD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PWSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/pwsd_pkg.sv
// constants for the pulse width symbol decoder
// no dependencies
`timescale 1ns / 1ps

package pwsd_pkg;

    localparam int CNT_W    = 32;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int SAMPLE_W = 17;
    localparam int SYM_W    = 8;
    localparam int REM_W    = 25;
    localparam int DEN_W    = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_SAMPLES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_STOP = 2'd2;

    localparam logic [CFG_W-1:0] THRESHOLD_RST = 16'd50;
    localparam logic [CFG_W-1:0] BIT_SAMPLES_RST = 16'd100;
    localparam logic [CFG_W-1:0] GAP_STOP_RST = 16'd100;

    localparam logic [SYM_W-1:0] SYM_MIN = 8'd32;
    localparam logic [CNT_W-1:0] CNT_MAX = 32'hFFFF_FFFF;

endpackage

>>> hdl/pulse_width_symbol_decoder_core.sv
// pulse width symbol decoder: burst length to symbol, shared restoring divider
// depends on pwsd_pkg and pulse_width_symbol_decoder_core_defines.svh
`timescale 1ns / 1ps
`include "pulse_width_symbol_decoder_core_defines.svh"
//
// usage
// - input channel in_valid/in_ready carries one envelope_level word per sample
// - output channel out_valid/out_ready carries one symbol_value word per burst
//   that decodes into 32..255; other bursts end silently
// - cfg channel cfg_valid/cfg_ready writes threshold, bit_samples, gap stop
//   by cfg_index; cfg_ready is always high, write only while the block is idle
// - a sample that does not end a burst leaves in_ready high
// - a sample that ends a burst runs length adjust, range check and eight
//   steps of one shared compare/subtract unit, then the done state: out_valid
//   rises as the sequencer leaves the done state and in_ready returns with it
// - a burst dropped as too short never leaves idle, one whose quotient reaches
//   256 returns from the range check, one below 32 runs the full sequence
// - if out_ready is low when the next symbol is done, the sequencer waits in
//   its last state with in_ready low until the pending word is taken
// - reset clears counters, sequencer and output valid and loads register
//   defaults 50 / 100 / 100
//
module pulse_width_symbol_decoder_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pwsd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pwsd_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [pwsd_pkg::SAMPLE_W-1:0] envelope_level,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [pwsd_pkg::SYM_W-1:0]        symbol_value
);
    import pwsd_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ADJ   = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [CFG_W-1:0]  thr_reg, bs_reg, gs_reg;
    logic [CNT_W-1:0]  burst_reg, burst_next;
    logic [CFG_W-1:0]  gap_reg, gap_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [SYM_W-1:0]  quo_reg, quo_next;
    logic [2:0]        step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic [SYM_W-1:0]  sym_reg, sym_next;

    logic              accept;
    logic              high;
    logic [CNT_W-1:0]  burst_inc;
    logic [CFG_W:0]    gap_inc;
    logic [CFG_W:0]    min_len;
    logic [CNT_W+1:0]  num;
    logic [CNT_W+1:0]  limit;
    logic [REM_W:0]    trial;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign symbol_value = sym_reg;
    assign accept = in_valid && in_ready;

    assign high = !envelope_level[SAMPLE_W-1]
        && (envelope_level[SAMPLE_W-2:0] >= thr_reg);
    assign burst_inc = (burst_reg == CNT_MAX) ? burst_reg : burst_reg + 32'd1;
    assign gap_inc = {1'b0, gap_reg} + 17'd1;
    assign min_len = ({1'b0, bs_reg} + 17'd1) >> 1;
    assign num = {1'b0, len_reg, 1'b0} + {18'd0, bs_reg};
    assign limit = {9'd0, bs_reg, 9'd0};
    assign trial = {1'b0, rem_reg} - {2'b00, den_reg};

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THRESHOLD_RST;
            bs_reg  <= BIT_SAMPLES_RST;
            gs_reg  <= GAP_STOP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD:   thr_reg <= cfg_data;
                CFG_BIT_SAMPLES: bs_reg  <= cfg_data;
                CFG_GAP_STOP:    gs_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        burst_next     = burst_reg;
        gap_next       = gap_reg;
        len_next       = len_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        sym_next       = sym_reg;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (burst_reg == '0)
                    begin
                        if (high)
                            burst_next = 32'd1;
                    end
                    else if (high)
                    begin
                        burst_next = burst_inc;
                        gap_next   = '0;
                    end
                    else if (gap_inc >= {1'b0, gs_reg})
                    begin
                        // burst ends
                        burst_next = '0;
                        gap_next   = '0;
                        len_next   = burst_inc;
                        if (burst_inc >= {15'd0, min_len})
                            state_next = ST_ADJ;
                    end
                    else
                    begin
                        burst_next = burst_inc;
                        gap_next   = gap_inc[CFG_W-1:0];
                    end
                end
            end
            ST_ADJ:
            begin
                len_next = (len_reg >= {16'd0, gs_reg})
                    ? len_reg - {16'd0, gs_reg} : '0;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                // quotient of 256 or more, or zero divisor
                if (num >= limit)
                    state_next = ST_IDLE;
                else
                begin
                    rem_next   = num[REM_W-1:0];
                    den_next   = {bs_reg, 8'd0};
                    quo_next   = '0;
                    step_next  = 3'd7;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (!trial[REM_W])
                begin
                    rem_next = trial[REM_W-1:0];
                    quo_next = {quo_reg[SYM_W-2:0], 1'b1};
                end
                else
                    quo_next = {quo_reg[SYM_W-2:0], 1'b0};
                den_next  = den_reg >> 1;
                step_next = step_reg - 3'd1;
                if (step_reg == 3'd0)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    if (quo_reg >= SYM_MIN)
                    begin
                        sym_next       = quo_reg;
                        out_valid_next = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            burst_reg     <= '0;
            gap_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            burst_reg     <= burst_next;
            gap_reg       <= gap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        len_reg  <= len_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
        sym_reg  <= sym_next;
    end

    `PWSD_ASSERT_NOW(a_sym_range, out_valid, symbol_value >= SYM_MIN, "symbol below range")
    `PWSD_ASSERT_NEXT(a_idle_no_end, accept && (burst_reg == '0), state_reg == ST_IDLE,
        "burst ended while none was active")
    `PWSD_ASSERT_NOW(a_div_rem, state_reg == ST_DIV,
        {1'b0, rem_reg} < {1'b0, den_reg, 1'b0}, "divider remainder out of bound")
    `PWSD_ASSERT_NOW(a_gap_in_burst, gap_reg != '0, burst_reg != '0,
        "gap counted outside a burst")

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// testbench for pulse_width_symbol_decoder_core: directed and random envelope samples
// shaped into carrier bursts, a burst-length predictor and an in-order symbol_value check
// depends on pwsd_pkg and the decoder core

module testbench;
    import pwsd_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 16;
    localparam int SYM_TOP = 255;
    localparam int MIN_SAMPLES = 1950;
    localparam int MIN_SYMBOLS = 60;
    localparam int MAX_SAMPLES = 12000;
    localparam int PHASE_SAMPLES = 160;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [SAMPLE_W-1:0] envelope_level = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [SYM_W-1:0] symbol_value;

    // predicted decoder state
    logic [CFG_W-1:0] threshold_q = THRESHOLD_RST;
    logic [CFG_W-1:0] bit_samples_q = BIT_SAMPLES_RST;
    logic [CFG_W-1:0] gap_stop_q = GAP_STOP_RST;
    logic [CNT_W-1:0] burst_len = '0;
    logic [CNT_W-1:0] low_run = '0;

    logic [SAMPLE_W-1:0] sample_queue[$];
    logic [SYM_W-1:0] symbol_expect[$];

    int samples_pushed = 0;
    int samples_accepted = 0;
    int cfg_writes = 0;
    int symbols_predicted = 0;
    int symbols_checked = 0;
    int bursts_silent = 0;
    int mismatches = 0;
    int cycle_count = 0;
    int settings_run = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic in_taken = 1'b0;

    wire sample_fire = in_valid && (in_ready === 1'b1);
    wire symbol_fire = out_ready && (out_valid === 1'b1);
    wire cfg_fire = cfg_valid && (cfg_ready === 1'b1);

    pulse_width_symbol_decoder_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .envelope_level (envelope_level),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .symbol_value   (symbol_value)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // one sample through the burst counters, returns 1 when a symbol comes out
    function automatic bit decode_step(input logic [SAMPLE_W-1:0] level,
                                       output logic [SYM_W-1:0] sym, output bit burst_done);
        logic [CNT_W-1:0] len;
        logic [CNT_W-1:0] divisor;
        logic [CNT_W-1:0] min_len;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] quot;
        bit carrier;
        bit found;
        carrier = !level[SAMPLE_W-1] && (level[CFG_W-1:0] >= threshold_q);
        sym = '0;
        burst_done = 1'b0;
        found = 1'b0;
        if (burst_len == '0)
        begin
            if (carrier)
                burst_len = 1;
        end
        else
        begin
            if (burst_len != CNT_MAX)
                burst_len = burst_len + 1;
            if (carrier)
                low_run = '0;
            else
            begin
                if (low_run != CNT_MAX)
                    low_run = low_run + 1;
                if (low_run >= gap_stop_q)
                begin
                    len = burst_len;
                    burst_len = '0;
                    low_run = '0;
                    burst_done = 1'b1;
                    divisor = {16'd0, bit_samples_q};
                    min_len = (divisor + 1) >> 1;
                    if (len >= min_len)
                    begin
                        len = (len >= gap_stop_q) ? len - gap_stop_q : '0;
                        if (divisor == '0)
                            quot = '1;
                        else
                        begin
                            num = {32'd0, len};
                            num = 2 * num + divisor;
                            den = {32'd0, divisor};
                            den = 2 * den;
                            quot = num / den;
                        end
                        if (quot >= SYM_MIN && quot <= SYM_TOP)
                        begin
                            sym = quot[SYM_W-1:0];
                            found = 1'b1;
                        end
                    end
                end
            end
        end
        return found;
    endfunction

    always @(posedge clk)
    begin : scoreboard
        logic [SYM_W-1:0] sym;
        logic [SYM_W-1:0] want;
        bit done;
        if (rst_n)
        begin
            in_taken <= sample_fire;
            if (cfg_fire)
            begin
                case (cfg_index)
                    CFG_THRESHOLD: threshold_q = cfg_data;
                    CFG_BIT_SAMPLES: bit_samples_q = cfg_data;
                    CFG_GAP_STOP: gap_stop_q = cfg_data;
                    default: ;
                endcase
                cfg_writes++;
            end
            if (symbol_fire)
            begin
                if (symbol_expect.size() == 0)
                begin
                    $error("symbol_value: no word expected, got %0d", symbol_value);
                    mismatches++;
                end
                else
                begin
                    want = symbol_expect.pop_front();
                    if (symbol_value !== want)
                    begin
                        $error("symbol_value: expected %0d, got %0d", want, symbol_value);
                        mismatches++;
                    end
                    symbols_checked++;
                end
            end
            if (sample_fire)
            begin
                if (decode_step(envelope_level, sym, done))
                begin
                    symbol_expect.push_back(sym);
                    symbols_predicted++;
                end
                else if (done)
                    bursts_silent++;
                samples_accepted++;
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            if (sample_queue.size() != 0 && $urandom_range(99, 0) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                envelope_level <= sample_queue.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        out_ready <= rst_n && ($urandom_range(99, 0) >= recv_stall_pct);
    end

    function automatic logic [SAMPLE_W-1:0] carrier_level(input logic [CFG_W-1:0] thr);
        logic [CFG_W-1:0] v;
        v = 16'($urandom_range(16'hFFFF, thr));
        return {1'b0, v};
    endfunction

    function automatic logic [SAMPLE_W-1:0] quiet_level(input logic [CFG_W-1:0] thr);
        logic [CFG_W-1:0] v;
        v = 16'($urandom_range(16'hFFFF, 0));
        if (thr == '0 || $urandom_range(3, 0) == 0)
            return {1'b1, v};
        v = 16'($urandom_range(thr - 1, 0));
        return {1'b0, v};
    endfunction

    task automatic push_sample(input logic [SAMPLE_W-1:0] v);
        sample_queue.push_back(v);
        samples_pushed++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        int n;
        n = cfg_writes;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        while (cfg_writes == n)
            @(negedge clk);
    endtask

    task automatic load_config(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] bs,
                               input logic [CFG_W-1:0] gs);
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_BIT_SAMPLES, bs);
        write_reg(CFG_GAP_STOP, gs);
        cfg_valid <= 1'b0;
        settings_run++;
    endtask

    task automatic wait_drained;
        while (samples_accepted != samples_pushed || symbol_expect.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // carrier run with short dips, then the stop gap and up to three trailing quiet samples; or a short random run
    task automatic add_burst(input logic [CFG_W-1:0] thr, input int bs, input int gs);
        int kind;
        int pick;
        int sym_target;
        int run;
        int dip;
        int k;
        kind = $urandom_range(9, 0);
        if (kind == 9)
        begin
            repeat ($urandom_range(8, 1)) push_sample(17'($urandom));
        end
        else
        begin
            if (kind < 7 && bs <= 3)
            begin
                pick = $urandom_range(9, 0);
                if (pick < 5)
                    sym_target = $urandom_range(40, 26);
                else if (pick < 8)
                    sym_target = $urandom_range(262, 26);
                else
                    sym_target = $urandom_range(262, 248);
                run = sym_target * bs + $urandom_range(bs - 1, 0);
            end
            else
                run = $urandom_range(bs + 2, 1);
            push_sample(carrier_level(thr));
            k = 1;
            while (k < run)
            begin
                if (gs > 1 && $urandom_range(19, 0) == 0)
                begin
                    dip = $urandom_range(gs - 1, 1);
                    repeat (dip) push_sample(quiet_level(thr));
                    k += dip;
                end
                else
                begin
                    push_sample(carrier_level(thr));
                    k++;
                end
            end
            repeat (gs) push_sample(quiet_level(thr));
            repeat ($urandom_range(3, 0)) push_sample(quiet_level(thr));
        end
    endtask

    initial
    begin : stimulus
        logic [CFG_W-1:0] thr;
        logic [CFG_W-1:0] bs;
        logic [CFG_W-1:0] gs;
        int phase_start;
        int pick;
        rst_n = 1'b0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // threshold edge, short burst dropped, burst decoding below symbol range
        load_config(16'd1000, 16'd9, 16'd2);
        push_sample(17'h10000);
        push_sample(17'h1FFFF);
        push_sample(17'd0);
        push_sample(17'd999);
        push_sample(17'd1000);
        push_sample(17'd65535);
        push_sample(17'h10000);
        push_sample(17'd999);
        repeat (4) push_sample(17'd1000);
        push_sample(17'd0);
        push_sample(17'd0);
        wait_drained();

        // zero threshold: negative samples stay quiet
        load_config(16'd0, 16'd1, 16'd1);
        push_sample(17'h1FFFF);
        push_sample(17'h10000);
        push_sample(17'd0);
        push_sample(17'h1FFFF);
        push_sample(17'd65535);
        push_sample(17'h10000);
        wait_drained();

        // top settings, burst left open into the next setting
        load_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
        repeat (60)
        begin
            pick = $urandom_range(2, 0);
            if (pick == 0)
                push_sample(17'd65535);
            else if (pick == 1)
                push_sample(quiet_level(16'hFFFF));
            else
                push_sample(17'($urandom));
        end
        wait_drained();

        while ((samples_pushed < MIN_SAMPLES || symbols_predicted < MIN_SYMBOLS)
               && samples_pushed < MAX_SAMPLES)
        begin
            case (settings_run % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 68;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 68;
                end
                default:
                begin
                    send_idle_pct = 24;
                    recv_stall_pct = 24;
                end
            endcase
            pick = $urandom_range(9, 0);
            if (pick == 0)
                thr = '0;
            else if (pick == 1)
                thr = 16'hFFFF;
            else
                thr = 16'($urandom_range(16'hFFFF, 0));
            pick = $urandom_range(9, 0);
            if (pick < 6)
                bs = 16'd1;
            else if (pick < 8)
                bs = 16'($urandom_range(3, 2));
            else
                bs = 16'($urandom_range(40, 10));
            gs = ($urandom_range(9, 0) < 3) ? 16'd1 : 16'($urandom_range(8, 2));
            load_config(thr, bs, gs);
            phase_start = samples_pushed;
            while (samples_pushed - phase_start < PHASE_SAMPLES)
                add_burst(thr, int'(bs), int'(gs));
            wait_drained();
        end

        $display("covered %0d samples under %0d register settings and four idling mixes",
                 samples_accepted, settings_run);
        $display("%0d symbols checked, %0d bursts ended without a symbol",
                 symbols_checked, bursts_silent);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
